@@ rtl/plid_pkg.sv @@
// Shared types, codes and defaults for the positional list block.
package plid_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int CNT_W          = 6;
  localparam int POS_W          = 6;
  localparam int ELEM_W         = 32;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // status codes
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]              operation;
    logic [POS_W-1:0]        position;
    logic signed [ELEM_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [ELEM_W-1:0] element;
    logic [CNT_W-1:0]        count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the input beat
    logic judge;     // latch status, clear element, seed cursor
    logic fetch;     // read entry at position
    logic grab;      // capture read data as element
    logic ins_step;  // move one entry up
    logic del_step;  // move one entry down
    logic put;       // write new value at position
    logic commit;    // update count
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ok;
    logic is_ins;
    logic is_del;
    logic ins_more;
    logic del_more;
  } stat_t;

endpackage

@@ rtl/plid_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module plid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/plid_ctrl.sv @@
// Sequencer for the positional list: accept, check, shift, respond.
module plid_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  plid_pkg::stat_t stat,
  output plid_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            out_valid
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_GRAB  = 3'd2;
  localparam logic [2:0] S_INS   = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_DEL   = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       idle_c;

  assign idle_c    = (state_r == S_IDLE) || (state_r == S_RESP);
  assign busy      = !idle_c;
  assign out_valid = (state_r == S_RESP);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE, S_RESP: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CHECK: begin
        cmd.judge = 1'b1;
        if (!stat.ok) begin
          cmd.commit = 1'b1;
          state_nxt  = S_RESP;
        end else if (stat.is_ins) begin
          state_nxt = S_INS;
        end else begin
          cmd.fetch = 1'b1;
          state_nxt = S_GRAB;
        end
      end
      S_GRAB: begin
        cmd.grab = 1'b1;
        if (stat.is_del) begin
          state_nxt = S_DEL;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_INS: begin
        if (stat.ins_more) begin
          cmd.ins_step = 1'b1;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        cmd.commit = 1'b1;
        state_nxt  = S_RESP;
      end
      S_DEL: begin
        if (stat.del_more) begin
          cmd.del_step = 1'b1;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/plid_dp.sv @@
// Datapath for the positional list: item registers, cursor, entry RAM, result.
module plid_dp #(
  parameter int DEPTH      = plid_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = plid_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  plid_pkg::in_item_t  in_item,
  input  plid_pkg::cmd_t      cmd,
  output plid_pkg::stat_t     stat,
  output plid_pkg::out_item_t out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = plid_pkg::CNT_W;
  localparam int EW = plid_pkg::ELEM_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // captured item
  logic [1:0]           op_r;
  logic [CW-1:0]        pos_r;
  logic [EW-1:0]        val_r;
  // result and list state
  logic [1:0]           status_r;
  logic [EW-1:0]        elem_r;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        cursor_r;
  // pending move write
  logic                 mv_r;
  logic [AW-1:0]        mv_addr_r;

  logic [1:0]           status_c;
  logic                 pos_zero, ins_pos_ok, rd_pos_ok, full_c;
  logic [CW-1:0]        pos_m1, cur_m1, cur_p1;
  logic [CW:0]          cur_p1_w;
  logic                 re, we;
  logic [AW-1:0]        raddr, waddr;
  logic [DATA_WIDTH-1:0] wdata, rdata, store_val;
  logic [EW-1:0]        rd_elem;

  assign pos_zero   = (pos_r == '0);
  assign ins_pos_ok = !pos_zero && ({1'b0, pos_r} <= ({1'b0, cnt_r} + (CW+1)'(1)));
  assign rd_pos_ok  = !pos_zero && (pos_r <= cnt_r);
  assign full_c     = (cnt_r == DEPTH_C);

  always_comb begin
    case (op_r)
      plid_pkg::OP_INSERT: begin
        if (!ins_pos_ok)  status_c = plid_pkg::ST_BADPOS;
        else if (full_c)  status_c = plid_pkg::ST_FULL;
        else              status_c = plid_pkg::ST_DONE;
      end
      plid_pkg::OP_DELETE, plid_pkg::OP_READ: begin
        status_c = rd_pos_ok ? plid_pkg::ST_DONE : plid_pkg::ST_BADPOS;
      end
      default: status_c = plid_pkg::ST_BADPOS;
    endcase
  end

  assign pos_m1   = pos_r - CW'(1);
  assign cur_m1   = cursor_r - CW'(1);
  assign cur_p1   = cursor_r + CW'(1);
  assign cur_p1_w = {1'b0, cursor_r} + (CW+1)'(1);

  assign stat.ok       = (status_c == plid_pkg::ST_DONE);
  assign stat.is_ins   = (op_r == plid_pkg::OP_INSERT);
  assign stat.is_del   = (op_r == plid_pkg::OP_DELETE);
  assign stat.ins_more = (cursor_r != pos_m1);
  assign stat.del_more = (cur_p1_w < {1'b0, cnt_r});

  // width adaptation between the 32-bit field and the stored word
  generate
    if (DATA_WIDTH > EW) begin : g_wide
      assign store_val = {{(DATA_WIDTH-EW){1'b0}}, val_r};
      assign rd_elem   = rdata[EW-1:0];
    end else if (DATA_WIDTH == EW) begin : g_same
      assign store_val = val_r;
      assign rd_elem   = rdata;
    end else begin : g_narrow
      assign store_val = val_r[DATA_WIDTH-1:0];
      assign rd_elem   = {{(EW-DATA_WIDTH){rdata[DATA_WIDTH-1]}}, rdata};
    end
  endgenerate

  // RAM port steering
  always_comb begin
    re    = cmd.fetch || cmd.ins_step || cmd.del_step;
    raddr = pos_m1[AW-1:0];
    if (cmd.ins_step) raddr = cur_m1[AW-1:0];
    if (cmd.del_step) raddr = cur_p1[AW-1:0];
    we    = mv_r || cmd.put;
    waddr = mv_r ? mv_addr_r : pos_m1[AW-1:0];
    wdata = mv_r ? rdata : store_val;
  end

  plid_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      mv_r  <= 1'b0;
    end else begin
      mv_r <= cmd.ins_step || cmd.del_step;
      if (cmd.commit && stat.ok) begin
        if (op_r == plid_pkg::OP_INSERT)      cnt_r <= cnt_r + CW'(1);
        else if (op_r == plid_pkg::OP_DELETE) cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_item.operation;
      pos_r <= in_item.position;
      val_r <= in_item.value;
    end
    if (cmd.judge) begin
      status_r <= status_c;
      elem_r   <= '0;
      cursor_r <= (op_r == plid_pkg::OP_INSERT) ? cnt_r : pos_m1;
    end
    if (cmd.grab) begin
      elem_r <= rd_elem;
    end
    if (cmd.ins_step) begin
      mv_addr_r <= cursor_r[AW-1:0];
      cursor_r  <= cur_m1;
    end
    if (cmd.del_step) begin
      mv_addr_r <= cursor_r[AW-1:0];
      cursor_r  <= cur_p1;
    end
  end

  assign out_item.status  = status_r;
  assign out_item.element = elem_r;
  assign out_item.count   = cnt_r;

endmodule

@@ rtl/positional_list_insert_delete.sv @@
// Top level of the positional list: ordered signed words, insert/delete/read by position.
//
// Keeps up to DEPTH words in a single-port-write RAM plus an entry count. A beat is
// accepted when start is high and busy is low; exactly one result comes back on
// out_result, flagged by a one-cycle out_valid strobe, and the receiver cannot stall
// it. Time from the accepting edge to the strobe depends on the operation: a bad
// position, full list or unused code is answered from the check state, a read
// after one RAM fetch, delete and insert after a shift loop from the given position to
// the end of the list, which moves one entry per cycle through the RAM's single write
// port (registered read feeding the write of the next cycle). busy drops in the
// strobe cycle, so the next beat can be taken while the result is on the ports.
// Entries that were never written hold unknown data, but only entries below the
// count are ever read. No clearing pass follows reset; the block is ready at once.
module positional_list_insert_delete #(
  parameter int DEPTH      = plid_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = plid_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  plid_pkg::in_item_t  in_item,
  output logic                out_valid,
  output plid_pkg::out_item_t out_result
);

  plid_pkg::cmd_t  cmd;
  plid_pkg::stat_t stat;

  // sequencer: one state per phase, one RAM move per cycle in the shift states
  plid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // datapath: item capture, range checks, cursor, entry RAM, result registers
  plid_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_result)
  );

  localparam logic [plid_pkg::CNT_W-1:0] DEPTH_C = plid_pkg::CNT_W'(DEPTH);

  // one result per beat: out_valid falls again after every strobe
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // an accepted beat is always being worked on in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted beat not in progress");

  // count never exceeds the list depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result.count <= DEPTH_C))
    else $error("entry count above depth");

  // a full status is only reported when the list really is full
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result.status == plid_pkg::ST_FULL)) |->
      (out_result.count == DEPTH_C))
    else $error("full status with room left");

  // a rejected beat leaves no element behind
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result.status != plid_pkg::ST_DONE)) |->
      (out_result.element == '0))
    else $error("element nonzero on rejected beat");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the positional list insert/delete/read block.
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH = plid_pkg::DEPTH_DEF;
  // operation code with no function; the block answers with a bad-position status
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [plid_pkg::ELEM_W-1:0] MAX_POS_VAL = 32'sh7FFF_FFFF;
  localparam logic signed [plid_pkg::ELEM_W-1:0] MIN_NEG_VAL = 32'sh8000_0000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  plid_pkg::in_item_t  in_item;
  logic                out_valid;
  plid_pkg::out_item_t out_result;

  positional_list_insert_delete dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  // Shadow copy of the list: updated in issue order, once per accepted beat.
  logic signed [plid_pkg::ELEM_W-1:0] shadow_list [0:DEPTH-1];
  int                                 shadow_len;

  // Predicted replies, oldest first. One per accepted beat.
  plid_pkg::out_item_t reply_q [$];
  plid_pkg::out_item_t head_reply;

  int sender_idle_pct;
  int error_cnt;
  int beats_sent;
  int replies_seen;
  int peak_len;
  int done_ins, done_del, done_read, bad_pos_hits, full_hits;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Apply one operation to the shadow list and return the reply it should produce.
  // Position is checked before fullness on insert.
  function automatic plid_pkg::out_item_t apply_list_op(input plid_pkg::in_item_t beat);
    plid_pkg::out_item_t r;
    int                  pos;
    int                  i;
    pos       = beat.position;
    r.status  = plid_pkg::ST_DONE;
    r.element = '0;
    case (beat.operation)
      plid_pkg::OP_INSERT: begin
        if (pos < 1 || pos > shadow_len + 1) begin
          r.status = plid_pkg::ST_BADPOS;
        end else if (shadow_len >= DEPTH) begin
          r.status = plid_pkg::ST_FULL;
        end else begin
          for (i = shadow_len; i > pos - 1; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos-1] = beat.value;
          shadow_len++;
        end
      end
      plid_pkg::OP_DELETE: begin
        if (pos < 1 || pos > shadow_len) begin
          r.status = plid_pkg::ST_BADPOS;
        end else begin
          r.element = shadow_list[pos-1];
          for (i = pos - 1; i < shadow_len - 1; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      plid_pkg::OP_READ: begin
        if (pos < 1 || pos > shadow_len) r.status = plid_pkg::ST_BADPOS;
        else                             r.element = shadow_list[pos-1];
      end
      default: r.status = plid_pkg::ST_BADPOS;
    endcase
    r.count = shadow_len[plid_pkg::CNT_W-1:0];
    return r;
  endfunction

  function automatic plid_pkg::in_item_t mk_beat(input logic [1:0] op, input int pos,
                                                 input logic signed [plid_pkg::ELEM_W-1:0] val);
    plid_pkg::in_item_t b;
    b.operation = op;
    b.position  = pos[plid_pkg::POS_W-1:0];
    b.value     = val;
    return b;
  endfunction

  // Out-of-range position for a list whose last legal position is lim.
  function automatic int bad_pos(input int lim);
    if (lim >= 63 || $urandom_range(2) == 0) return 0;
    return $urandom_range(63, lim + 1);
  endfunction

  function automatic logic signed [plid_pkg::ELEM_W-1:0] rand_value();
    if ($urandom_range(7) != 0) return $urandom();
    case ($urandom_range(3))
      0:       return MAX_POS_VAL;
      1:       return MIN_NEG_VAL;
      2:       return '0;
      default: return -1;
    endcase
  endfunction

  task automatic note_error(input string what, input plid_pkg::out_item_t want,
                            input plid_pkg::out_item_t got);
    error_cnt++;
    if (error_cnt <= 10)
      $display("[%0t] %s: exp status=%0d elem=%0d count=%0d, got status=%0d elem=%0d %s%0d",
               $realtime, what, want.status, want.element, want.count,
               got.status, got.element, "count=", got.count);
  endtask

  // Send one beat: optional random idle cycles, then hold start until busy is low
  // at a rising edge. The prediction is made at the accepting edge.
  task automatic send_beat(input plid_pkg::in_item_t beat);
    plid_pkg::out_item_t want;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= beat;
    do @(posedge clk); while (busy !== 1'b0);
    want = apply_list_op(beat);
    reply_q.push_back(want);
    beats_sent++;
    if (shadow_len > peak_len) peak_len = shadow_len;
    if (want.status == plid_pkg::ST_BADPOS)         bad_pos_hits++;
    else if (want.status == plid_pkg::ST_FULL)      full_hits++;
    else if (beat.operation == plid_pkg::OP_INSERT) done_ins++;
    else if (beat.operation == plid_pkg::OP_DELETE) done_del++;
    else done_read++;
  endtask

  // Drop start and hold off until every predicted reply has come back.
  task automatic wait_all_replies();
    start <= 1'b0;
    do @(posedge clk); while (reply_q.size() != 0);
  endtask

  // Reply checker: the receiver cannot stall, so every strobe is one beat.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      replies_seen++;
      if (reply_q.size() == 0) begin
        note_error("reply with nothing pending", '0, out_result);
      end else begin
        head_reply = reply_q.pop_front();
        if (out_result.status !== head_reply.status)
          note_error("status mismatch", head_reply, out_result);
        else if (out_result.element !== head_reply.element)
          note_error("element mismatch", head_reply, out_result);
        else if (out_result.count !== head_reply.count)
          note_error("count mismatch", head_reply, out_result);
      end
    end
  end

  // Operations on an empty list: all rejected, plus the unused opcode.
  task automatic test_empty_list();
    send_beat(mk_beat(plid_pkg::OP_READ,   1, 32'sh1234_5678));
    send_beat(mk_beat(plid_pkg::OP_DELETE, 1, '0));
    send_beat(mk_beat(plid_pkg::OP_INSERT, 0, -1));
    send_beat(mk_beat(plid_pkg::OP_INSERT, 2, -1));
    send_beat(mk_beat(OP_UNUSED,           1, MAX_POS_VAL));
    send_beat(mk_beat(plid_pkg::OP_READ,   0, '0));
    wait_all_replies();
  endtask

  // Front, middle and end inserts with extreme values, then the matching
  // reads and deletes; value is nonzero on some deletes and reads to show it's ignored.
  task automatic test_list_edges();
    send_beat(mk_beat(plid_pkg::OP_INSERT,  1, MAX_POS_VAL));
    send_beat(mk_beat(plid_pkg::OP_INSERT,  1, MIN_NEG_VAL));
    send_beat(mk_beat(plid_pkg::OP_INSERT,  3, -1));
    send_beat(mk_beat(plid_pkg::OP_INSERT,  2, '0));
    send_beat(mk_beat(plid_pkg::OP_READ,    1, 32'sh5A5A_5A5A));
    send_beat(mk_beat(plid_pkg::OP_READ,    4, 32'sh5A5A_5A5A));
    send_beat(mk_beat(plid_pkg::OP_READ,    5, '0));
    send_beat(mk_beat(plid_pkg::OP_READ,   63, '0));
    send_beat(mk_beat(plid_pkg::OP_DELETE, 63, '0));
    send_beat(mk_beat(plid_pkg::OP_DELETE,  2, 32'shA5A5_A5A5));
    send_beat(mk_beat(plid_pkg::OP_DELETE,  3, '0));
    send_beat(mk_beat(plid_pkg::OP_DELETE,  1, '0));
    send_beat(mk_beat(plid_pkg::OP_READ,    1, '0));
    wait_all_replies();
  endtask

  // Fill to DEPTH at random legal positions, then poke the full list.
  task automatic test_full_list();
    while (shadow_len < DEPTH)
      send_beat(mk_beat(plid_pkg::OP_INSERT, $urandom_range(shadow_len + 1, 1),
                        rand_value()));
    send_beat(mk_beat(plid_pkg::OP_INSERT, DEPTH + 1, 32'sh0BAD_0BAD)); // legal spot, no room
    send_beat(mk_beat(plid_pkg::OP_INSERT, 1, 32'sh0BAD_0BAD));
    send_beat(mk_beat(plid_pkg::OP_INSERT, DEPTH + 2, '0));             // range wins over full
    send_beat(mk_beat(plid_pkg::OP_INSERT, 0, '0));
    send_beat(mk_beat(plid_pkg::OP_READ,   DEPTH, '0));
    send_beat(mk_beat(plid_pkg::OP_DELETE, DEPTH, '0));
    send_beat(mk_beat(plid_pkg::OP_INSERT, DEPTH, MIN_NEG_VAL));
    send_beat(mk_beat(plid_pkg::OP_READ,   DEPTH + 1, '0));
    wait_all_replies();
  endtask

  // Random traffic. A grow/shrink mode walks the count between empty and full;
  // most beats are legal, a few are out of range or use the unused opcode.
  task automatic test_random_ops(input int n_items, input int idle_pct);
    plid_pkg::in_item_t beat;
    int                 k;
    int                 ins_pct;
    bit                 grow;
    sender_idle_pct = idle_pct;
    grow = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if (shadow_len >= DEPTH)         grow = 1'b0;
      else if (shadow_len == 0)        grow = 1'b1;
      else if ($urandom_range(39) == 0) grow = !grow;
      ins_pct    = grow ? 65 : 25;
      beat.value = rand_value();
      if ($urandom_range(99) < 8) begin
        case ($urandom_range(3))
          0: begin
            beat.operation = OP_UNUSED;
            beat.position  = plid_pkg::POS_W'($urandom_range(63));
          end
          1: begin
            beat.operation = plid_pkg::OP_INSERT;
            beat.position  = plid_pkg::POS_W'(bad_pos(shadow_len + 1));
          end
          2: begin
            beat.operation = plid_pkg::OP_DELETE;
            beat.position  = plid_pkg::POS_W'(bad_pos(shadow_len));
          end
          default: begin
            beat.operation = plid_pkg::OP_READ;
            beat.position  = plid_pkg::POS_W'(bad_pos(shadow_len));
          end
        endcase
      end else if (shadow_len == 0 || $urandom_range(99) < ins_pct) begin
        beat.operation = plid_pkg::OP_INSERT;
        beat.position  = plid_pkg::POS_W'($urandom_range(shadow_len + 1, 1));
      end else begin
        beat.operation = $urandom_range(1) ? plid_pkg::OP_DELETE : plid_pkg::OP_READ;
        beat.position  = plid_pkg::POS_W'($urandom_range(shadow_len, 1));
      end
      send_beat(beat);
      if ($urandom_range(99) == 0) wait_all_replies();
    end
    wait_all_replies();
  endtask

  initial begin
    int waited;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_item         = '0;
    shadow_len      = 0;
    sender_idle_pct = 22;
    error_cnt       = 0;
    beats_sent      = 0;
    replies_seen    = 0;
    peak_len        = 0;
    done_ins        = 0;
    done_del        = 0;
    done_read       = 0;
    bad_pos_hits    = 0;
    full_hits       = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_list_edges();
    test_full_list();
    test_random_ops(450, 22);
    test_random_ops(450, 84);
    test_random_ops(450, 0);

    // flush: longest op is an insert at the front of a nearly full list
    start  <= 1'b0;
    waited = 0;
    while (reply_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DEPTH + 8) @(posedge clk);
    if (reply_q.size() != 0) begin
      error_cnt++;
      $display("%0d predicted replies never arrived", reply_q.size());
    end

    $display("Run: %0d beats, %0d replies; inserts %0d, deletes %0d, reads %0d done",
             beats_sent, replies_seen, done_ins, done_del, done_read);
    $display("Rejected: %0d bad position, %0d list full; peak length %0d; errors %0d",
             bad_pos_hits, full_hits, peak_len, error_cnt);
    if (error_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/plid_pkg.sv
rtl/plid_ram.sv
rtl/plid_ctrl.sv
rtl/plid_dp.sv
rtl/positional_list_insert_delete.sv
tb/tb.sv
